FILE: rtl/sstf_pkg.sv
// Shared types, constants and segment helpers for the seven-segment text formatter.
package sstf_pkg;

   localparam int IN_CHARS        = 5;
   localparam int CHAR_W          = 8;
   localparam int LEN_W           = 3;
   localparam int ADDR_W          = 4;
   localparam int SEG_W           = 8;
   localparam int REQ_DATA_W      = 48;
   localparam int RSP_DATA_W      = 16;
   localparam int TEXT_PLACES_DEF = 5;
   localparam int DIGIT_COUNT_DEF = 4;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [SEG_W-1:0]  seg_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic has_dot;
      logic point_left;
      logic must_mark;
   } job_ctrl_type;

   localparam char_type CHAR_DOT   = 8'h2E;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_MINUS = 8'h2D;
   localparam char_type CHAR_EIGHT = 8'h38;

   localparam seg_type SEG_MINUS = 8'h40;
   localparam seg_type SEG_POINT = 8'h80;
   localparam seg_type SEG_MARK  = 8'h48;
   localparam seg_type SEG_BLANK = 8'h00;

   localparam seg_type DIGIT_CODES [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };
   localparam addr_type ADDR_TABLE [4] = '{4'd8, 4'd6, 4'd2, 4'd0};

   localparam logic [LEN_W-1:0] LEN_MAX = 3'd5;

   function automatic seg_type seg_of(input char_type c);
      seg_type s;
      s = SEG_BLANK;
      if (c inside {[8'h30:8'h39]}) begin
         s = DIGIT_CODES[c[3:0]];
      end else if (c == CHAR_MINUS) begin
         s = SEG_MINUS;
      end
      return s;
   endfunction

   function automatic addr_type addr_of(input logic [3:0] k);
      logic [4:0] dbl;
      dbl = {k, 1'b0};
      if (k < 4'd4) begin
         return ADDR_TABLE[k[1:0]];
      end
      return dbl[ADDR_W-1:0];
   endfunction

endpackage

FILE: rtl/sstf_front.sv
// Request register, text compare, stored text and job setup for the formatter.
module sstf_front #(
   parameter int TEXT_PLACES = sstf_pkg::TEXT_PLACES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sstf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              emit_free,
   output logic                              start,
   output sstf_pkg::char_type                job_text [TEXT_PLACES],
   output logic [$clog2(TEXT_PLACES)-1:0]    job_pidx,
   output sstf_pkg::job_ctrl_type            job_ctrl
);
   import sstf_pkg::*;

   localparam int IW = $clog2(TEXT_PLACES);
   localparam int CW = $clog2(TEXT_PLACES + 1);

   logic             in_valid_ff, in_valid_in;
   char_type         chars_ff [IN_CHARS];
   logic [LEN_W-1:0] len_ff;
   logic             must_ff;

   char_type         stored_ff [IN_CHARS];
   char_type         stored_in [IN_CHARS];
   logic [LEN_W-1:0] stored_len_ff, stored_len_in;

   logic [LEN_W-1:0] len;
   logic [CW-1:0]    kept, pad;
   logic             same, in_adv, req_take, has_dot;
   logic [2:0]       dpos;

   assign req_take = req_tvalid && req_tready;
   assign len      = (len_ff > LEN_MAX) ? LEN_MAX : len_ff;
   assign kept     = (int'(len) < TEXT_PLACES) ? CW'(len) : CW'(TEXT_PLACES);
   assign pad      = CW'(TEXT_PLACES) - kept;

   always_comb begin
      same = (len == stored_len_ff);
      for (int c = 0; c < IN_CHARS; c++) begin
         if (c < int'(len) && chars_ff[c] != stored_ff[c]) begin
            same = 1'b0;
         end
      end
   end

   assign in_adv     = in_valid_ff && (same || emit_free);
   assign start      = in_adv && !same;
   assign req_tready = !in_valid_ff || in_adv;

   always_comb begin
      for (int j = 0; j < TEXT_PLACES; j++) begin
         job_text[j] = CHAR_SPACE;
         for (int c = 0; c < IN_CHARS; c++) begin
            if (c < int'(kept) && int'(pad) + c == j) begin
               job_text[j] = chars_ff[c];
            end
         end
      end
   end

   always_comb begin
      has_dot = 1'b0;
      dpos    = 3'd0;
      for (int c = IN_CHARS - 1; c >= 0; c--) begin
         if (c < int'(kept) && chars_ff[c] == CHAR_DOT) begin
            has_dot = 1'b1;
            dpos    = 3'(c);
         end
      end
   end

   assign job_ctrl.has_dot    = has_dot;
   assign job_ctrl.point_left = (pad == '0) && (dpos == 3'd0);
   assign job_ctrl.must_mark  = must_ff;
   assign job_pidx            = IW'(int'(pad) + int'(dpos) - 1);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (in_adv) begin
         in_valid_in = 1'b0;
      end
      stored_len_in = stored_len_ff;
      for (int c = 0; c < IN_CHARS; c++) begin
         stored_in[c] = stored_ff[c];
      end
      if (start) begin
         stored_len_in = len;
         for (int c = 0; c < IN_CHARS; c++) begin
            stored_in[c] = (c < int'(len)) ? chars_ff[c] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         stored_len_ff <= LEN_MAX;
         stored_ff[0]  <= CHAR_EIGHT;
         stored_ff[1]  <= CHAR_EIGHT;
         stored_ff[2]  <= CHAR_EIGHT;
         stored_ff[3]  <= CHAR_DOT;
         stored_ff[4]  <= CHAR_EIGHT;
      end else begin
         in_valid_ff   <= in_valid_in;
         stored_len_ff <= stored_len_in;
         for (int c = 0; c < IN_CHARS; c++) begin
            stored_ff[c] <= stored_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int c = 0; c < IN_CHARS; c++) begin
            chars_ff[c] <= req_tdata[c*CHAR_W +: CHAR_W];
         end
         len_ff  <= req_tdata[IN_CHARS*CHAR_W +: LEN_W];
         must_ff <= req_tuser;
      end
   end

endmodule

FILE: rtl/sstf_emit.sv
// Digit sequencer, response reg: rightmost first, one write per cycle bar stall/dot.
module sstf_emit #(
   parameter int TEXT_PLACES = sstf_pkg::TEXT_PLACES_DEF,
   parameter int DIGIT_COUNT = sstf_pkg::DIGIT_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  sstf_pkg::char_type                job_text [TEXT_PLACES],
   input  logic [$clog2(TEXT_PLACES)-1:0]    job_pidx,
   input  sstf_pkg::job_ctrl_type            job_ctrl,
   output logic                              emit_free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sstf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import sstf_pkg::*;

   localparam int IW  = $clog2(TEXT_PLACES);
   localparam int DGW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   logic          busy_ff, busy_in;
   char_type      text_ff [TEXT_PLACES];
   logic [IW-1:0] pidx_ff;
   job_ctrl_type  ctrl_ff;
   logic [IW-1:0] pos_ff, pos_in;
   logic          below_ff, below_in;
   logic          first_below_ff, first_below_in;
   logic [DGW-1:0] dig_ff, dig_in;

   logic          rsp_valid_ff, rsp_valid_in;
   addr_type      addr_ff;
   seg_type       seg_ff;
   logic          last_ff;

   char_type      cur_char;
   seg_type       seg;
   logic          is_dot, point, last, step, produce, done;

   assign cur_char = below_ff ? CHAR_SPACE : text_ff[pos_ff];
   assign is_dot   = !below_ff && (cur_char == CHAR_DOT);
   assign point    = ctrl_ff.has_dot &&
                     (below_ff ? (first_below_ff && ctrl_ff.point_left)
                               : (!ctrl_ff.point_left && pos_ff == pidx_ff));
   assign last     = (dig_ff == DGW'(DIGIT_COUNT - 1));
   assign step     = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign produce  = step && !is_dot;
   assign done     = produce && last;
   assign emit_free = !busy_ff || done;

   always_comb begin
      if (point) begin
         seg = seg_of(cur_char) | SEG_POINT;
      end else if (last && ctrl_ff.must_mark) begin
         seg = SEG_MARK;
      end else begin
         seg = seg_of(cur_char);
      end
   end

   always_comb begin
      busy_in        = busy_ff;
      pos_in         = pos_ff;
      below_in       = below_ff;
      first_below_in = first_below_ff;
      dig_in         = dig_ff;
      if (start) begin
         busy_in        = 1'b1;
         pos_in         = IW'(TEXT_PLACES - 1);
         below_in       = 1'b0;
         first_below_in = 1'b0;
         dig_in         = '0;
      end else if (step) begin
         if (below_ff) begin
            first_below_in = 1'b0;
         end else if (pos_ff == '0) begin
            below_in       = 1'b1;
            first_below_in = 1'b1;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
         if (produce) begin
            dig_in = dig_ff + 1'b1;
         end
         if (done) begin
            busy_in = 1'b0;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      below_ff       <= below_in;
      first_below_ff <= first_below_in;
      dig_ff         <= dig_in;
      if (start) begin
         for (int j = 0; j < TEXT_PLACES; j++) begin
            text_ff[j] <= job_text[j];
         end
         pidx_ff <= job_pidx;
         ctrl_ff <= job_ctrl;
      end
      if (produce) begin
         addr_ff <= addr_of(4'(dig_ff));
         seg_ff  <= seg;
         last_ff <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ADDR_W - SEG_W){1'b0}}, seg_ff, addr_ff};
   assign rsp_tlast  = last_ff;

endmodule

FILE: rtl/seven_segment_text_formatter_unit.sv
// Path: a changed text passes the request register, the sequencer's text register and the response
// register before its first digit write shows; each dot passed on the way costs a sequencer step.
// Throughput: one digit write per cycle from the digit sequencer while the response is not stalled
// and no dot is passed; a changed text gives DIGIT_COUNT digit writes, and the request register can
// hold the next text meanwhile; an unchanged text is dropped with no write.
// Reset clears all valid flags and restores the stored text "888.8" with length 5.
module seven_segment_text_formatter_unit #(
   parameter int TEXT_PLACES = sstf_pkg::TEXT_PLACES_DEF,
   parameter int DIGIT_COUNT = sstf_pkg::DIGIT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_0, char_1, char_2, char_3, char_4, text_length, zero fill
   input  logic [sstf_pkg::REQ_DATA_W-1:0] req_tdata,
   // must_mark
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // register_address, segment_bits, zero fill
   output logic [sstf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);
   import sstf_pkg::*;

   logic                           start, emit_free;
   char_type                       job_text [TEXT_PLACES];
   logic [$clog2(TEXT_PLACES)-1:0] job_pidx;
   job_ctrl_type                   job_ctrl;

   sstf_front #(
      .TEXT_PLACES(TEXT_PLACES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .emit_free  (emit_free),
      .start      (start),
      .job_text   (job_text),
      .job_pidx   (job_pidx),
      .job_ctrl   (job_ctrl)
   );

   sstf_emit #(
      .TEXT_PLACES(TEXT_PLACES),
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .job_text   (job_text),
      .job_pidx   (job_pidx),
      .job_ctrl   (job_ctrl),
      .emit_free  (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/sstf_checker.sv
// Port-level checker for the seven-segment text formatter and its bind.
module sstf_checker #(
   parameter int DIGIT_COUNT = sstf_pkg::DIGIT_COUNT_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sstf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import sstf_pkg::*;

   localparam addr_type LAST_ADDR = addr_of(4'(DIGIT_COUNT - 1));

   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("response valid or request blocked right after reset");

   addr_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[0])
      else $error("odd digit address");

   last_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[ADDR_W-1:0] == LAST_ADDR)
      else $error("final digit write at wrong address");

endmodule

bind seven_segment_text_formatter_unit sstf_checker #(
   .DIGIT_COUNT(DIGIT_COUNT)
) u_sstf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: sim/seven_segment_text_formatter_unit_tb.sv
// Testbench for the seven-segment text formatter: directed table plus random texts, self-checked.
`timescale 1ns / 1ps

module seven_segment_text_formatter_unit_tb;
   import sstf_pkg::*;

   localparam int PLACES      = TEXT_PLACES_DEF;
   localparam int DIGITS      = DIGIT_COUNT_DEF;
   localparam int QUIET_LIMIT = 1000;
   localparam int ROWS        = 25;
   localparam int RANDOM_ROWS = 325;

   typedef logic [IN_CHARS-1:0][CHAR_W-1:0] text_type;

   typedef struct packed {
      addr_type addr;
      seg_type  seg;
      logic     last;
   } digit_write_type;

   // text in reading order, leftmost character in the top byte; segs: first write in top byte
   typedef struct packed {
      logic [39:0] text;
      logic [2:0]  len;
      logic        mark;
      logic        typed;
      logic [2:0]  count;
      logic [31:0] segs;
   } text_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // char_0, char_1, char_2, char_3, char_4, text_length, zero fill
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // must_mark
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // register_address, segment_bits, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   digit_write_type pending_writes [$];
   char_type        shown_text [IN_CHARS] = '{CHAR_EIGHT, CHAR_EIGHT, CHAR_EIGHT, CHAR_DOT,
                                              CHAR_EIGHT};
   int unsigned     shown_len = 5;
   int              mismatch_count = 0;
   int              sent_count = 0;
   int              writes_seen = 0;
   int              quiet_cycles = 0;

   text_row_type directed_rows [ROWS] = '{
      '{"888.8", 3'd5, 1'b0, 1'b1, 3'd0, 32'h0},
      '{"     ", 3'd0, 1'b0, 1'b1, 3'd4, 32'h0},
      '{"12345", 3'd0, 1'b1, 1'b1, 3'd0, 32'h0},
      '{"88888", 3'd7, 1'b0, 1'b1, 3'd4, 32'h7F7F7F7F},
      '{"88888", 3'd5, 1'b1, 1'b1, 3'd0, 32'h0},
      '{"-9876", 3'd5, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"01234", 3'd5, 1'b1, 1'b0, 3'd0, 32'h0},
      '{"12.34", 3'd5, 1'b0, 1'b0, 3'd0, 32'h0},
      '{".1234", 3'd5, 1'b1, 1'b0, 3'd0, 32'h0},
      '{"1.2.3", 3'd5, 1'b0, 1'b0, 3'd0, 32'h0},
      '{".....", 3'd5, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"12   ", 3'd2, 1'b1, 1'b0, 3'd0, 32'h0},
      '{".5   ", 3'd2, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"8.888", 3'd5, 1'b1, 1'b0, 3'd0, 32'h0},
      '{"AbZ?~", 3'd5, 1'b0, 1'b1, 3'd4, 32'h0},
      '{40'hFF_00_80_7F_55, 3'd5, 1'b1, 1'b1, 3'd4, 32'h00000048},
      '{40'h00_00_00_41_42, 3'd3, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"123ab", 3'd3, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"123-.", 3'd3, 1'b1, 1'b1, 3'd0, 32'h0},
      '{"5.5.5", 3'd6, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"-.-  ", 3'd3, 1'b1, 1'b0, 3'd0, 32'h0},
      '{"7.   ", 3'd2, 1'b1, 1'b0, 3'd0, 32'h0},
      '{"0    ", 3'd1, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"    .", 3'd5, 1'b0, 1'b0, 3'd0, 32'h0},
      '{"4321-", 3'd4, 1'b1, 1'b0, 3'd0, 32'h0}
   };

   seven_segment_text_formatter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int format_text(input text_type txt, input logic [2:0] raw_len,
                                      input logic mark);
      int              len, pad, i, p, digit;
      logic            same, has_dot;
      char_type        buffer [PLACES];
      char_type        c;
      seg_type         s;
      digit_write_type w;
      len = (raw_len > IN_CHARS) ? IN_CHARS : int'(raw_len);
      same = (len == shown_len);
      for (int j = 0; j < len; j++) begin
         if (txt[j] != shown_text[j]) begin
            same = 1'b0;
         end
      end
      if (same) begin
         return 0;
      end
      for (int j = 0; j < IN_CHARS; j++) begin
         shown_text[j] = (j < len) ? txt[j] : '0;
      end
      shown_len = len;
      pad = PLACES - len;
      for (int j = 0; j < PLACES; j++) begin
         buffer[j] = (j < pad) ? CHAR_SPACE : txt[j - pad];
      end
      has_dot = 1'b0;
      p = 0;
      for (int j = 0; j < len; j++) begin
         if (!has_dot && txt[j] == CHAR_DOT) begin
            has_dot = 1'b1;
            p = pad + j - 1;
         end
      end
      i = PLACES - 1;
      digit = 0;
      while (digit < DIGITS) begin
         if (i >= 0 && buffer[i] == CHAR_DOT) begin
            i--;
         end else begin
            c = (i >= 0) ? buffer[i] : CHAR_SPACE;
            if (c >= 8'h30 && c <= 8'h39) begin
               s = DIGIT_CODES[c - 8'h30];
            end else if (c == CHAR_MINUS) begin
               s = SEG_MINUS;
            end else begin
               s = SEG_BLANK;
            end
            if (has_dot && i == p) begin
               s = s | SEG_POINT;
            end else if (digit == DIGITS - 1 && mark) begin
               s = SEG_MARK;
            end
            w.addr = ADDR_TABLE[digit];
            w.seg = s;
            w.last = (digit == DIGITS - 1);
            pending_writes.push_back(w);
            digit++;
            i--;
         end
      end
      return DIGITS;
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   task automatic check_write();
      digit_write_type want;
      if (pending_writes.size() == 0) begin
         flag_mismatch("unexpected write", int'(rsp_tdata), 0);
      end else begin
         want = pending_writes.pop_front();
         if (rsp_tdata[3:0] != want.addr) begin
            flag_mismatch("register_address", rsp_tdata[3:0], want.addr);
         end
         if (rsp_tdata[11:4] != want.seg) begin
            flag_mismatch("segment_bits", rsp_tdata[11:4], want.seg);
         end
         if (rsp_tlast != want.last) begin
            flag_mismatch("last_write", rsp_tlast, want.last);
         end
      end
   endtask

   task automatic send_text(input text_type txt, input logic [2:0] len, input logic mark,
                            output int writes);
      int gap;
      gap = ((sent_count % 64) >= 48) ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, len, txt};
      req_tuser <= mark;
      do @(posedge clock); while (!req_tready);
      writes = format_text(txt, len, mark);
      sent_count++;
   endtask

   task automatic wait_for_display_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always begin : drain_writes
      int stall;
      stall = ((writes_seen % 100) >= 70) ? 0 : $urandom_range(0, 13);
      repeat (stall) begin
         @(negedge clock);
         rsp_tready <= 1'b0;
      end
      @(negedge clock);
      rsp_tready <= 1'b1;
      do @(posedge clock); while (reset || !rsp_tvalid);
      check_write();
      writes_seen++;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      text_row_type    row;
      text_type        txt;
      digit_write_type w;
      logic [2:0]      len;
      logic            mark;
      int              n, pick;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < ROWS; r++) begin
         row = directed_rows[r];
         for (int j = 0; j < IN_CHARS; j++) begin
            txt[j] = row.text[39 - 8 * j -: 8];
         end
         send_text(txt, row.len, row.mark, n);
         if (row.typed) begin
            repeat (n) void'(pending_writes.pop_back());
            for (int k = 0; k < row.count; k++) begin
               w.addr = ADDR_TABLE[k];
               w.seg = row.segs[31 - 8 * k -: 8];
               w.last = (k == DIGITS - 1);
               pending_writes.push_back(w);
            end
         end
      end
      wait_for_display_idle();

      for (int t = 0; t < RANDOM_ROWS; t++) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(3, 5));
         mark = $urandom_range(0, 1);
         for (int j = 0; j < IN_CHARS; j++) begin
            txt[j] = 8'($urandom_range(0, 255));
         end
         if (pick < 25) begin
            len = (shown_len == 5) ? 3'($urandom_range(5, 7)) : 3'(shown_len);
            for (int j = 0; j < shown_len; j++) begin
               txt[j] = shown_text[j];
            end
         end else if (pick < 75) begin
            for (int j = 0; j < IN_CHARS; j++) begin
               n = $urandom_range(0, 12);
               txt[j] = (n < 10) ? 8'(8'h30 + n) : (n == 10) ? CHAR_MINUS :
                        (n == 11) ? CHAR_DOT : CHAR_SPACE;
            end
         end
         send_text(txt, len, mark, n);
         if (t == RANDOM_ROWS / 2) begin
            wait_for_display_idle();
         end
      end

      wait_for_display_idle();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && pending_writes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
